/* sv/top_k_score_selector_assert.svh */
// Assertion helpers for the top-k selector, clocked on aclk, off while aresetn is low.
`ifndef TOP_K_SCORE_SELECTOR_ASSERT_SVH
`define TOP_K_SCORE_SELECTOR_ASSERT_SVH

// Same-cycle implication.
`define TKS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tks_pkg.sv */
`timescale 1ns / 1ps
package tks_pkg;

    localparam int MAX_SELECT = 16;
    localparam int IDX_W      = $clog2(MAX_SELECT);
    localparam int CNT_W      = $clog2(MAX_SELECT + 1);
    localparam int SCORE_W    = 32;
    localparam int PAYLOAD_W  = 64;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 104;
    localparam int CFG_W      = 5;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [PAYLOAD_W-1:0]      payload;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic shift_en;
    } cell_ctl_t;

endpackage

/* sv/tks_cell.sv */
`timescale 1ns / 1ps
module tks_cell (
    input  logic                     aclk,
    input  tks_pkg::cell_ctl_t       ctl,
    input  logic [tks_pkg::IDX_W-1:0] cell_idx,
    input  logic [tks_pkg::CNT_W-1:0] fill_cnt,
    input  tks_pkg::entry_t          new_ent,
    input  logic                     left_beats,
    input  tks_pkg::entry_t          left_ent,
    input  tks_pkg::entry_t          right_ent,
    output logic                     beats,
    output tks_pkg::entry_t          ent
);

    tks_pkg::entry_t ent_reg;
    tks_pkg::entry_t ent_next;
    logic            occupied;

    assign occupied = ({1'b0, cell_idx} < fill_cnt);
    // strict compare: an equal score stays behind the earlier arrival
    assign beats    = !occupied || ($signed(new_ent.score) > $signed(ent_reg.score));
    assign ent      = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        if (ctl.ins_en) begin
            if (left_beats) begin
                ent_next = left_ent;
            end else if (beats) begin
                ent_next = new_ent;
            end
        end else if (ctl.shift_en) begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

/* sv/top_k_score_selector.sv */
`timescale 1ns / 1ps
// channel  | ports     | tdata fields (low bit up)                  | tlast
// ---------+-----------+--------------------------------------------+----------
// in       | s_t*      | score[31:0], payload[95:32]                | batch_end
// out      | m_t*      | sel_payload[63:0], sel_score[95:64],       | run_end
//          |           | rank[99:96], zero pad[103:100]             |
// cfg      | cfg_we    | count_to_select on cfg_wdata[4:0]          | -
//
// One candidate per cycle while idle: all cells compare against the incoming score and
// the list shifts by one place behind the insertion point in the same cycle.
// After a batch end the list drains through cell 0, one result per cycle while
// m_tready is high; input is held off until the last result is loaded, if any.
// Reset (aresetn low, synchronous) empties the list and sets count_to_select to 1.
module top_k_score_selector (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tks_pkg::IN_DATA_W-1:0]  s_tdata,   // score, payload
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tks_pkg::OUT_DATA_W-1:0] m_tdata,   // sel_payload, sel_score, rank, pad
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [tks_pkg::CFG_W-1:0]      cfg_wdata
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t                       state_reg;
    logic [tks_pkg::CNT_W-1:0]    cnt_reg;
    logic [tks_pkg::CFG_W-1:0]    cts_reg;
    logic [tks_pkg::CNT_W-1:0]    rem_reg;
    logic [tks_pkg::IDX_W-1:0]    rank_reg;
    logic                         m_tvalid_reg;
    logic                         m_tlast_reg;
    tks_pkg::entry_t              out_ent_reg;
    logic [tks_pkg::IDX_W-1:0]    out_rank_reg;

    tks_pkg::entry_t              new_ent;
    tks_pkg::entry_t              cell_ent   [tks_pkg::MAX_SELECT];
    logic                         cell_beats [tks_pkg::MAX_SELECT];
    tks_pkg::cell_ctl_t           ctl;
    logic                         in_acc;
    logic                         out_load;
    logic [tks_pkg::CNT_W-1:0]    cts_sat;
    logic [tks_pkg::CNT_W-1:0]    cnt_after;
    logic [tks_pkg::CNT_W-1:0]    n_emit;

    assign new_ent.score   = $signed(s_tdata[tks_pkg::SCORE_W-1:0]);
    assign new_ent.payload = s_tdata[tks_pkg::SCORE_W +: tks_pkg::PAYLOAD_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DRAIN) && (!m_tvalid_reg || m_tready);

    assign ctl.ins_en   = in_acc;
    assign ctl.shift_en = out_load;

    always_comb begin
        if ({{(32 - tks_pkg::CFG_W){1'b0}}, cts_reg} > tks_pkg::MAX_SELECT) begin
            cts_sat = tks_pkg::CNT_W'(tks_pkg::MAX_SELECT);
        end else begin
            cts_sat = tks_pkg::CNT_W'(cts_reg);
        end
        if (cnt_reg == tks_pkg::CNT_W'(tks_pkg::MAX_SELECT)) begin
            cnt_after = cnt_reg;
        end else begin
            cnt_after = cnt_reg + 1'b1;
        end
        n_emit = (cts_sat < cnt_after) ? cts_sat : cnt_after;
    end

    for (genvar i = 0; i < tks_pkg::MAX_SELECT; i++) begin : g_cell
        logic            left_beats;
        tks_pkg::entry_t left_ent;
        tks_pkg::entry_t right_ent;
        if (i == 0) begin : g_head
            assign left_beats = 1'b0;
            assign left_ent   = '0;
        end else begin : g_body
            assign left_beats = cell_beats[i-1];
            assign left_ent   = cell_ent[i-1];
        end
        if (i == tks_pkg::MAX_SELECT - 1) begin : g_tail
            assign right_ent = '0;
        end else begin : g_inner
            assign right_ent = cell_ent[i+1];
        end
        tks_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .cell_idx   (tks_pkg::IDX_W'(i)),
            .fill_cnt   (cnt_reg),
            .new_ent    (new_ent),
            .left_beats (left_beats),
            .left_ent   (left_ent),
            .right_ent  (right_ent),
            .beats      (cell_beats[i]),
            .ent        (cell_ent[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            cts_reg      <= tks_pkg::CFG_W'(1);
            rem_reg      <= '0;
            rank_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                cts_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (!s_tlast) begin
                            cnt_reg <= cnt_after;
                        end else if (n_emit == '0) begin
                            cnt_reg <= '0;
                        end else begin
                            cnt_reg   <= cnt_after;
                            rem_reg   <= n_emit;
                            rank_reg  <= '0;
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (out_load) begin
                        out_ent_reg  <= cell_ent[0];
                        out_rank_reg <= rank_reg;
                        m_tlast_reg  <= (rem_reg == tks_pkg::CNT_W'(1));
                        m_tvalid_reg <= 1'b1;
                        rem_reg      <= rem_reg - 1'b1;
                        rank_reg     <= rank_reg + 1'b1;
                        // list drops toward cell 0; occupancy no longer matters
                        if (rem_reg == tks_pkg::CNT_W'(1)) begin
                            cnt_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {{(tks_pkg::OUT_DATA_W - tks_pkg::PAYLOAD_W - tks_pkg::SCORE_W
                        - tks_pkg::IDX_W){1'b0}},
                       out_rank_reg, out_ent_reg.score, out_ent_reg.payload};

`include "top_k_score_selector_assert.svh"

    `TKS_ASSERT_NOW(a_fill_bounded, 1'b1, cnt_reg <= tks_pkg::CNT_W'(tks_pkg::MAX_SELECT), "fill count above list depth")
    `TKS_ASSERT_NOW(a_drain_nonempty, state_reg == ST_DRAIN, rem_reg != '0, "drain with nothing left to emit")
    `TKS_ASSERT_NOW(a_head_sorted, state_reg == ST_IDLE && cnt_reg >= tks_pkg::CNT_W'(2), $signed(cell_ent[0].score) >= $signed(cell_ent[1].score), "kept list out of order")
    `TKS_ASSERT_NEXT(a_last_ends_drain, out_load && rem_reg == tks_pkg::CNT_W'(1), state_reg == ST_IDLE && cnt_reg == '0, "list not cleared after final result")

endmodule

/* tb/sv/top_k_score_selector_checker.sv */
`timescale 1ns / 1ps
// Watches the candidate, selection and config channels, keeps its own
// ranked list and compares every selection item with the oldest one due.
module top_k_score_selector_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tks_pkg::IN_DATA_W-1:0]  s_tdata,   // score, payload
    input  logic                           s_tlast,   // batch_end
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [tks_pkg::OUT_DATA_W-1:0] m_tdata,   // sel_payload, sel_score, rank, pad
    input  logic                           m_tlast,   // run_end
    input  logic                           cfg_we,
    input  logic [tks_pkg::CFG_W-1:0]      cfg_wdata,
    output int                             mismatches,
    output int                             pending
);
    import tks_pkg::*;

    typedef struct packed {
        logic [PAYLOAD_W-1:0]      payload;
        logic signed [SCORE_W-1:0] score;
        logic [IDX_W-1:0]          rank;
        logic                      run_end;
    } selection_t;

    entry_t           ranked [MAX_SELECT];
    int               ranked_len   = 0;
    logic [CFG_W-1:0] select_limit = 5'd1;
    selection_t       due_selections [$];
    int               miss_count   = 0;

    assign mismatches = miss_count;

    task automatic flag_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        miss_count++;
    endtask

    // Sorted insert; equal scores stay behind earlier arrivals.
    function automatic void place_candidate(input entry_t cand);
        int pos;
        int last;
        pos = 0;
        while (pos < ranked_len && ranked[pos].score >= cand.score)
            pos++;
        if (pos >= MAX_SELECT)
            return;
        last = (ranked_len < MAX_SELECT) ? ranked_len : MAX_SELECT - 1;
        for (int i = last; i > pos; i--)
            ranked[i] = ranked[i-1];
        ranked[pos] = cand;
        if (ranked_len < MAX_SELECT)
            ranked_len++;
    endfunction

    function automatic void release_batch();
        int         n;
        selection_t sel;
        n = (int'(select_limit) < MAX_SELECT) ? int'(select_limit) : MAX_SELECT;
        if (n > ranked_len)
            n = ranked_len;
        for (int k = 0; k < n; k++) begin
            sel.payload = ranked[k].payload;
            sel.score   = ranked[k].score;
            sel.rank    = IDX_W'(k);
            sel.run_end = (k + 1 == n);
            due_selections.push_back(sel);
        end
        ranked_len = 0;
    endfunction

    always @(posedge aclk) begin : watch
        entry_t     cand;
        selection_t got;
        selection_t want;
        if (!aresetn) begin
            ranked_len   = 0;
            select_limit = 5'd1;
            due_selections.delete();
        end else begin
            if (cfg_we)
                select_limit = cfg_wdata;
            if (s_tvalid && s_tready) begin
                cand.score   = s_tdata[SCORE_W-1:0];
                cand.payload = s_tdata[SCORE_W +: PAYLOAD_W];
                place_candidate(cand);
                if (s_tlast)
                    release_batch();
            end
            if (m_tvalid && m_tready) begin
                got.payload = m_tdata[PAYLOAD_W-1:0];
                got.score   = m_tdata[PAYLOAD_W +: SCORE_W];
                got.rank    = m_tdata[PAYLOAD_W + SCORE_W +: IDX_W];
                got.run_end = m_tlast;
                if (due_selections.size() == 0) begin
                    flag_mismatch($sformatf("selection item with none due: score %0d",
                                            got.score));
                end else begin
                    want = due_selections.pop_front();
                    if (got.payload !== want.payload)
                        flag_mismatch($sformatf("sel_payload %h, want %h",
                                                got.payload, want.payload));
                    if (got.score !== want.score)
                        flag_mismatch($sformatf("sel_score %0d, want %0d",
                                                got.score, want.score));
                    if (got.rank !== want.rank)
                        flag_mismatch($sformatf("rank %0d, want %0d",
                                                got.rank, want.rank));
                    if (got.run_end !== want.run_end)
                        flag_mismatch($sformatf("run_end %b, want %b",
                                                got.run_end, want.run_end));
                end
            end
        end
        pending = due_selections.size();
    end

endmodule

/* tb/sv/top_k_score_selector_tb.sv */
`timescale 1ns / 1ps
module top_k_score_selector_tb;
    import tks_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // score, payload
    logic                  s_tlast;   // batch_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;   // sel_payload, sel_score, rank, pad
    logic                  m_tlast;   // run_end
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  steady = 1'b0;
    int                    mismatches;
    int                    pending;
    int                    items_sent = 0;

    top_k_score_selector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    top_k_score_selector_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (!aresetn || steady)
            m_tready <= aresetn;
        else
            m_tready <= ($urandom_range(99) >= 21);
    end

    // Entered and left at a falling edge; valid stays high into the next item.
    task automatic send_candidate(input logic [SCORE_W-1:0] score,
                                  input logic [PAYLOAD_W-1:0] payload,
                                  input logic batch_end);
        while (!steady && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {payload, score};
        s_tlast  <= batch_end;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Only while idle: every selection item drained, then a quiet pause before the write.
    task automatic set_select_count(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_count();
        case ($urandom_range(7))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'd31;
            4:       return 5'd15;
            default: return CFG_W'($urandom_range(2, 17));
        endcase
    endfunction

    // small spread gives plenty of ties
    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(9))
            0, 1, 2, 3: return SCORE_W'($urandom_range(15)) - 32'd8;
            4:          return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [PAYLOAD_W-1:0] pick_payload();
        return {$urandom, $urandom};
    endfunction

    initial begin : stimulus
        int phase;
        int batches;
        int len;
        int guard;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // count_to_select still at its reset value of one
        send_candidate(32'h8000_0000, 64'h0, 1'b0);
        send_candidate(32'h7fff_ffff, '1, 1'b1);

        // zero requested: nothing out, list still cleared
        set_select_count(5'd0);
        send_candidate(32'd5, pick_payload(), 1'b0);
        send_candidate(32'd9, pick_payload(), 1'b1);

        // saturates to the list size; fewer candidates than requested; ties
        set_select_count(5'd31);
        send_candidate(32'd0, 64'h0000_0000_0000_00a1, 1'b0);
        send_candidate(32'd0, 64'h0000_0000_0000_00a2, 1'b0);
        send_candidate(32'hffff_ffff, 64'h0000_0000_0000_00a3, 1'b0);
        send_candidate(32'h7fff_ffff, 64'h0000_0000_0000_00a4, 1'b1);

        set_select_count(5'd3);
        send_candidate(pick_score(), pick_payload(), 1'b1);

        // full list: a tie with the last entry is dropped, a better one displaces it
        set_select_count(5'd16);
        for (int i = 0; i < MAX_SELECT; i++)
            send_candidate(SCORE_W'(100 - i), PAYLOAD_W'(i), 1'b0);
        send_candidate(32'd85, 64'hdead_0000_0000_0085, 1'b0);
        send_candidate(32'd86, 64'hbeef_0000_0000_0086, 1'b1);

        phase = 0;
        while (items_sent < 460) begin
            steady <= (phase == 2);
            set_select_count(pick_count());
            batches = $urandom_range(2, 5);
            repeat (batches) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(17, 40)
                                               : $urandom_range(1, 12);
                for (int j = 0; j < len; j++)
                    send_candidate(pick_score(), pick_payload(), j == len - 1);
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 5000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/tks_pkg.sv
sv/tks_cell.sv
sv/top_k_score_selector.sv
tb/sv/top_k_score_selector_checker.sv
tb/sv/top_k_score_selector_tb.sv
